// File: rtl/apr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apr_pkg
// Types and constants shared by the relocation patcher and its checker.
// ----------------------------------------------------------------------------
package apr_pkg;

	typedef enum logic [4:0] {
		OP_NONE      = 5'd0,
		OP_ABS32     = 5'd1,
		OP_REL32     = 5'd2,
		OP_BRANCH24  = 5'd3,
		OP_MOVW_ABS  = 5'd4,
		OP_MOVT_ABS  = 5'd5,
		OP_MOVW_PREL = 5'd6,
		OP_MOVT_PREL = 5'd7,
		OP_GOT_BREL  = 5'd8,
		OP_PLT32     = 5'd9,
		OP_ADD8      = 5'd10,
		OP_ADD16     = 5'd11,
		OP_ADD32     = 5'd12,
		OP_SUB8      = 5'd13,
		OP_SUB16     = 5'd14,
		OP_SUB32     = 5'd15
	} op_t;

	// first code that is not a relocation kind
	localparam logic [4:0] OP_FIRST_UNKNOWN = 5'd16;

	localparam logic [31:0] BRANCH_CLASS_MASK = 32'h0e00_0000;
	localparam logic [31:0] BRANCH_CLASS_VAL  = 32'h0a00_0000;
	localparam logic [31:0] MOV_IMM_MASK      = 32'h000f_0fff;
	localparam logic [31:0] BRANCH24_MASK     = 32'h00ff_ffff;
	localparam logic [31:0] PC_BIAS           = 32'd8;

	typedef struct packed {
		logic [4:0]         operation;
		logic [31:0]        symbol_value;
		logic signed [31:0] addend;
		logic [31:0]        place;
		logic [31:0]        old_word;
		logic               has_plt;
		logic [31:0]        plt_entry_address;
		logic [31:0]        got_entry_address;
		logic [31:0]        got_origin;
	} cmd_t;

	typedef struct packed {
		logic [31:0] new_word;
		logic        unsupported;
	} res_t;

	// branch offset field takes bits 25..2 of the displacement
	function automatic logic [31:0] put_branch(input logic [31:0] word,
			input logic [31:0] delta);
		return (word & ~BRANCH24_MASK) | {8'd0, delta[25:2]};
	endfunction

	// movw/movt immediate split into imm4 (19..16) and imm12 (11..0)
	function automatic logic [31:0] put_imm16(input logic [31:0] word,
			input logic [15:0] imm);
		return (word & ~MOV_IMM_MASK) | {12'd0, imm[15:12], 4'd0, imm[11:0]};
	endfunction

endpackage
`default_nettype wire

// File: rtl/arm_relocation_patcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_relocation_patcher
// Applies one ARM relocation to one 32-bit word per command.
// ----------------------------------------------------------------------------
// Usage:
//  - a command word (cmd) is taken at a rising edge where start is high and
//    busy is low; busy stays low, so a command can be issued every cycle
//  - cmd is registered, the patch is computed in one pass of adders and
//    muxes, and the patched word is registered onto res
//  - done is high with res valid once cmd_s1 and then res_s2 have taken the
//    command; one result per command, in command order
//  - throughput is one command per cycle, set by the single compute stage
//  - all sums wrap modulo 2^32; unknown kinds return the old word with
//    res.unsupported set, the no-op kind returns the old word unchanged
//  - the receiver cannot stall: each result must be taken while done is high
//  - arst_n clears the valid flags of both stages; commands in flight are
//    dropped, res is not cleared, and done stays low until a new command arrives
// ----------------------------------------------------------------------------
module arm_relocation_patcher (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           start,
	output logic          busy,
	input  apr_pkg::cmd_t cmd,
	output logic          done,
	output apr_pkg::res_t res
);
	import apr_pkg::*;

	cmd_t        cmd_s1;
	logic        valid_s1;
	res_t        res_s2;
	logic        valid_s2;

	logic [31:0] addend_u;
	logic [31:0] v_sum;
	logic [31:0] v_rel;
	logic [31:0] place_pc;
	logic [31:0] plt_sum;
	logic [31:0] br_target;
	logic [31:0] plt_target;
	logic [31:0] br_delta;
	logic [31:0] plt_delta;
	logic [7:0]  f8_add;
	logic [7:0]  f8_sub;
	logic [15:0] f16_add;
	logic [15:0] f16_sub;
	res_t        res_d;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
		end
	end

	assign addend_u   = cmd_s1.addend;
	assign v_sum      = cmd_s1.symbol_value + addend_u;
	assign v_rel      = v_sum - cmd_s1.place;
	assign place_pc   = cmd_s1.place + PC_BIAS;
	assign plt_sum    = cmd_s1.plt_entry_address + addend_u;
	assign br_target  = cmd_s1.has_plt ? plt_sum : v_sum;
	// plt32 falls back to S + A when there is no plt entry or it sums to zero
	assign plt_target = (cmd_s1.has_plt && plt_sum != 32'd0) ? plt_sum : v_sum;
	assign br_delta   = br_target - place_pc;
	assign plt_delta  = plt_target - place_pc;
	assign f8_add     = cmd_s1.old_word[7:0] + v_sum[7:0];
	assign f8_sub     = cmd_s1.old_word[7:0] - v_sum[7:0];
	assign f16_add    = cmd_s1.old_word[15:0] + v_sum[15:0];
	assign f16_sub    = cmd_s1.old_word[15:0] - v_sum[15:0];

	always_comb begin
		res_d.new_word    = cmd_s1.old_word;
		res_d.unsupported = 1'b0;
		unique case (cmd_s1.operation)
			OP_NONE:      res_d.new_word = cmd_s1.old_word;
			OP_ABS32:     res_d.new_word = v_sum;
			OP_REL32:     res_d.new_word = v_rel;
			OP_BRANCH24:  res_d.new_word = put_branch(cmd_s1.old_word, br_delta);
			OP_MOVW_ABS:  res_d.new_word = put_imm16(cmd_s1.old_word, v_sum[15:0]);
			OP_MOVT_ABS:  res_d.new_word = put_imm16(cmd_s1.old_word, v_sum[31:16]);
			OP_MOVW_PREL: res_d.new_word = put_imm16(cmd_s1.old_word, v_rel[15:0]);
			OP_MOVT_PREL: res_d.new_word = put_imm16(cmd_s1.old_word, v_rel[31:16]);
			OP_GOT_BREL:  res_d.new_word = cmd_s1.got_entry_address + addend_u
					- cmd_s1.got_origin;
			OP_PLT32: begin
				if ((cmd_s1.old_word & BRANCH_CLASS_MASK) == BRANCH_CLASS_VAL) begin
					res_d.new_word = put_branch(cmd_s1.old_word, plt_delta);
				end else begin
					res_d.new_word = plt_delta;
				end
			end
			OP_ADD8:      res_d.new_word = {cmd_s1.old_word[31:8], f8_add};
			OP_ADD16:     res_d.new_word = {cmd_s1.old_word[31:16], f16_add};
			OP_ADD32:     res_d.new_word = cmd_s1.old_word + v_sum;
			OP_SUB8:      res_d.new_word = {cmd_s1.old_word[31:8], f8_sub};
			OP_SUB16:     res_d.new_word = {cmd_s1.old_word[31:16], f16_sub};
			OP_SUB32:     res_d.new_word = cmd_s1.old_word - v_sum;
			default:      res_d.unsupported = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			res_s2 <= res_d;
		end
	end

	assign done = valid_s2;
	assign res  = res_s2;

endmodule
`default_nettype wire

// File: rtl/apr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks on the relocation patcher, bound into each of its instances.
// ----------------------------------------------------------------------------
module apr_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           start,
	input wire           busy,
	input apr_pkg::cmd_t cmd,
	input wire           done,
	input apr_pkg::res_t res
);
	import apr_pkg::*;

	// every result traces back to a command taken through the start/busy handshake
	a_done_follows_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("done without a command two cycles before");

	// a command taken with reset released long enough gives a result
	a_cmd_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("command produced no result");

	a_unsupported_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (res.unsupported == ($past(cmd.operation, 2) >= OP_FIRST_UNKNOWN)))
		else $error("unsupported flag does not match the command kind");

	// no-op and unknown kinds leave the word untouched
	a_word_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (res.unsupported || $past(cmd.operation, 2) == OP_NONE))
		|-> res.new_word == $past(cmd.old_word, 2))
		else $error("word changed for a kind that must keep it");

endmodule

bind arm_relocation_patcher apr_checker u_apr_checker (.*);
`default_nettype wire

// File: tb/arm_relocation_patcher_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_relocation_patcher_tb
// Self-checking bench for the relocation patcher. Commands are driven through
// the start/busy handshake and a local model of every relocation kind predicts
// the patched word and the unsupported flag. A checker compares each result
// against the oldest prediction. Directed corner cases come first, followed by
// random branch/plt work, a random mix of all codes with idle bursts, and a
// final stretch at full rate.
// ----------------------------------------------------------------------------
module arm_relocation_patcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apr_pkg::*;

	logic  clk;
	logic  arst_n;
	logic  start;
	logic  busy;
	cmd_t  cmd;
	logic  done;
	res_t  res;

	res_t  patch_queue[$];
	int    errors;
	bit    idle_on;

	arm_relocation_patcher uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.done   (done),
		.res    (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#200000;
		$display("arm_relocation_patcher_tb failed");
		$finish;
	end

	// branch offset lives in bits 23..0, taken from bits 25..2 of the delta
	function automatic logic [31:0] splice_branch(input logic [31:0] w,
			input logic [31:0] delta);
		return {w[31:24], delta[25:2]};
	endfunction

	// imm16 split: top nibble to 19..16, low twelve bits to 11..0
	function automatic logic [31:0] splice_imm16(input logic [31:0] w,
			input logic [15:0] imm);
		return {w[31:20], imm[15:12], w[15:12], imm[11:0]};
	endfunction

	function automatic res_t predict_patch(input cmd_t c);
		logic [31:0] v;
		logic [31:0] w;
		logic [31:0] t;
		logic [31:0] d;
		res_t        r;
		v = c.symbol_value + c.addend;
		w = c.old_word;
		d = v - c.place;
		r.new_word = w;
		r.unsupported = 1'b0;
		case (c.operation)
			OP_NONE: ;
			OP_ABS32:     r.new_word = v;
			OP_REL32:     r.new_word = d;
			OP_BRANCH24: begin
				t = c.has_plt ? c.plt_entry_address + c.addend : v;
				r.new_word = splice_branch(w, t - (c.place + PC_BIAS));
			end
			OP_MOVW_ABS:  r.new_word = splice_imm16(w, v[15:0]);
			OP_MOVT_ABS:  r.new_word = splice_imm16(w, v[31:16]);
			OP_MOVW_PREL: r.new_word = splice_imm16(w, d[15:0]);
			OP_MOVT_PREL: r.new_word = splice_imm16(w, d[31:16]);
			OP_GOT_BREL:  r.new_word = c.got_entry_address + c.addend - c.got_origin;
			OP_PLT32: begin
				t = c.has_plt ? c.plt_entry_address + c.addend : 32'd0;
				// no plt target falls back to the symbol itself
				if (t == 32'd0)
					t = v;
				t = t - (c.place + PC_BIAS);
				if ((w & BRANCH_CLASS_MASK) == BRANCH_CLASS_VAL)
					r.new_word = splice_branch(w, t);
				else
					r.new_word = t;
			end
			OP_ADD8:      r.new_word = {w[31:8], w[7:0] + v[7:0]};
			OP_ADD16:     r.new_word = {w[31:16], w[15:0] + v[15:0]};
			OP_ADD32:     r.new_word = w + v;
			OP_SUB8:      r.new_word = {w[31:8], w[7:0] - v[7:0]};
			OP_SUB16:     r.new_word = {w[31:16], w[15:0] - v[15:0]};
			OP_SUB32:     r.new_word = w - v;
			default:      r.unsupported = 1'b1;
		endcase
		return r;
	endfunction

	function automatic cmd_t make_cmd(input logic [4:0] op, input logic [31:0] s,
			input logic [31:0] a, input logic [31:0] p, input logic [31:0] w,
			input int plt, input logic [31:0] plt_addr,
			input logic [31:0] got_addr, input logic [31:0] got_org);
		cmd_t c;
		c.operation = op;
		c.symbol_value = s;
		c.addend = a;
		c.place = p;
		c.old_word = w;
		c.has_plt = plt[0];
		c.plt_entry_address = plt_addr;
		c.got_entry_address = got_addr;
		c.got_origin = got_org;
		return c;
	endfunction

	// biased towards wrap points and small magnitudes
	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hffff_ffff;
			2: return 32'h8000_0000;
			3: return 32'h7fff_ffff;
			4: return $urandom_range(0, 255);
			5: return -$urandom_range(0, 255);
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_t rand_cmd(input logic [4:0] op);
		return make_cmd(op, rand_value(), rand_value(), rand_value(), rand_value(),
				$urandom_range(0, 1), rand_value(), rand_value(), rand_value());
	endfunction

	// drive one command word and hold it until the handshake takes it
	task automatic send_word(input cmd_t c);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		patch_queue.push_back(predict_patch(c));
	endtask

	// hold off until every outstanding word has come back
	task automatic drain();
		start <= 1'b0;
		while (patch_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_directed();
		send_word(make_cmd(OP_NONE, '1, '1, '1, '1, 1'b1, '1, '1, '1));
		send_word(make_cmd(OP_ABS32, 32'hffff_ffff, 32'd1, 0, 32'h1234_5678, 0, 0, 0, 0));
		send_word(make_cmd(OP_ABS32, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_REL32, 0, 0, 32'hffff_ffff, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_BRANCH24, 32'h0001_0000, 0, 32'h0000_8000, '1,
				0, 32'hdead_beef, 0, 0));
		send_word(make_cmd(OP_BRANCH24, 32'h0001_0000, -32'd8, 32'h0002_0000,
				32'hea00_0000, 1, 32'h0000_8000, 0, 0));
		send_word(make_cmd(OP_MOVW_ABS, 32'h1234_abcd, 0, 0, '1, 0, 0, 0, 0));
		send_word(make_cmd(OP_MOVT_ABS, 32'h1234_abcd, 32'h0000_0033, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_MOVW_PREL, 32'h0000_1000, 0, 32'h0000_2000, '1, 0, 0, 0, 0));
		send_word(make_cmd(OP_MOVT_PREL, 32'h0000_1000, 0, 32'h0000_2000, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_GOT_BREL, 0, 32'hffff_fffc, 0, 0, 0, 0,
				32'h0000_0010, 32'hffff_fff0));
		send_word(make_cmd(OP_PLT32, 32'h0040_0000, 32'd4, 32'h0010_0000,
				32'heb00_0000, 0, 32'h0080_0000, 0, 0));
		send_word(make_cmd(OP_PLT32, 32'h0040_0000, 32'd4, 32'h0010_0000, 0,
				1, 32'h0080_0000, 0, 0));
		// plt entry plus addend lands on zero, so the symbol is used instead
		send_word(make_cmd(OP_PLT32, 32'h0040_0000, -32'h100, 32'h0010_0000,
				32'hea00_0000, 1, 32'h0000_0100, 0, 0));
		send_word(make_cmd(OP_PLT32, 32'h0000_0000, 0, 32'hffff_ffff,
				32'hfbff_ffff, 0, 0, 0, 0));
		send_word(make_cmd(OP_PLT32, 32'h1234_5678, 0, 0, 32'h0c00_0000, 0, 0, 0, 0));
		send_word(make_cmd(OP_ADD8, 32'd1, 0, 0, 32'h1234_56ff, 0, 0, 0, 0));
		send_word(make_cmd(OP_ADD16, 32'd1, 0, 0, '1, 0, 0, 0, 0));
		send_word(make_cmd(OP_ADD32, '1, '1, 0, '1, 0, 0, 0, 0));
		send_word(make_cmd(OP_SUB8, 32'd1, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_SUB16, 32'd0, 32'd1, 0, 32'hffff_0000, 0, 0, 0, 0));
		send_word(make_cmd(OP_SUB32, 32'd1, 0, 0, 0, 0, 0, 0, 0));
		send_word(make_cmd(OP_FIRST_UNKNOWN, '1, '1, '1, 32'hcafe_f00d, 1, '1, '1, '1));
		send_word(make_cmd(5'd31, 0, 0, 0, 32'h0bad_c0de, 0, 0, 0, 0));
	endtask

	task automatic test_branch_plt(input int count);
		cmd_t c;
		repeat (count) begin
			c = rand_cmd($urandom_range(0, 1) ? OP_BRANCH24 : OP_PLT32);
			// half the words look like a b/bl instruction
			if ($urandom_range(0, 1))
				c.old_word = (c.old_word & ~BRANCH_CLASS_MASK) | BRANCH_CLASS_VAL;
			if ($urandom_range(0, 3) == 0) begin
				c.has_plt = 1'b1;
				c.plt_entry_address = -c.addend;
			end
			send_word(c);
		end
	endtask

	task automatic test_random_ops(input int count);
		logic [4:0] op;
		repeat (count) begin
			if ($urandom_range(0, 6) == 0)
				op = 5'($urandom_range(OP_FIRST_UNKNOWN, 31));
			else
				op = 5'($urandom_range(0, OP_FIRST_UNKNOWN - 1));
			send_word(rand_cmd(op));
		end
	endtask

	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && done) begin
			if (patch_queue.size() == 0) begin
				$error("result word with no command outstanding");
				errors++;
			end else begin
				want = patch_queue.pop_front();
				if (res.new_word !== want.new_word) begin
					$error("new_word: expected %h, got %h", want.new_word, res.new_word);
					errors++;
				end
				if (res.unsupported !== want.unsupported) begin
					$error("unsupported: expected %b, got %b",
							want.unsupported, res.unsupported);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		idle_on = 1'b1;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain();
		test_branch_plt(300);
		drain();
		test_random_ops(1200);
		drain();
		// closing stretch back to back, no gaps
		idle_on = 1'b0;
		test_random_ops(300);
		drain();

		if (errors == 0 && patch_queue.size() == 0)
			$display("arm_relocation_patcher_tb passed");
		else
			$display("arm_relocation_patcher_tb failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: filelist.f
rtl/apr_pkg.sv
rtl/arm_relocation_patcher.sv
rtl/apr_checker.sv
tb/arm_relocation_patcher_tb.sv
